>>> hw/rtl/bounded_indexed_list_assert.svh
// assertion macros for the bounded indexed list
// used by the top level only, expects clk and rst_n in scope
`ifndef BOUNDED_INDEXED_LIST_ASSERT_SVH
`define BOUNDED_INDEXED_LIST_ASSERT_SVH

// same-cycle implication
`define BIL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BIL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bil_pkg.sv
// shared widths, codes and command types for the bounded indexed list
// no dependencies
package bil_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int CNT_W     = 5;
    localparam int POS_W     = 5;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT   = 3'd0,
        OP_APPEND      = 3'd1,
        OP_REMOVE_AT   = 3'd2,
        OP_REMOVE_LAST = 3'd3,
        OP_READ_AT     = 3'd4,
        OP_READ_LAST   = 3'd5,
        OP_CLEAR       = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_IDX = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_EMPTY   = 2'd3
    } stat_t;

    // controller to datapath
    typedef struct packed {
        logic load;   // latch the incoming request
        logic exec;   // run the request and load the result register
    } cmd_t;

endpackage

>>> hw/rtl/bil_ctrl.sv
// request sequencer for the bounded indexed list
// depends on bil_pkg
module bil_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output bil_pkg::cmd_t cmd
);
    import bil_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;
    logic   room;

    // result register free now or emptied at this edge
    assign room     = !out_valid_reg || !out_stall;
    assign cmd.load = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec = (state_reg == S_EXEC) && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    // waiting result word taken
                    if (out_valid_reg && !out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_valid)
                    begin
                        state_reg    <= S_EXEC;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    // without room the waiting word is still stalled
                    if (room)
                    begin
                        state_reg     <= S_IDLE;
                        in_stall_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/bil_dpath.sv
// entry array, shift network, count, capacity and result register
// depends on bil_pkg
module bil_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bil_pkg::cmd_t                cmd,
    input  logic [bil_pkg::OP_W-1:0]     opcode,
    input  logic [bil_pkg::POS_W-1:0]    position,
    input  bil_pkg::word_t               element,
    input  logic                         cap_we,
    input  logic [bil_pkg::CNT_W-1:0]    cap_data,
    output logic [bil_pkg::STAT_W-1:0]   status,
    output bil_pkg::word_t               read_value,
    output logic [bil_pkg::CNT_W-1:0]    count,
    output logic                         is_full,
    output logic                         is_empty
);
    import bil_pkg::*;

    // latched request
    logic [OP_W-1:0]  req_op_reg;
    logic [POS_W-1:0] req_pos_reg;
    word_t            req_elem_reg;

    word_t            entries_reg [MAX_DEPTH];
    word_t            entries_next [MAX_DEPTH];
    word_t            up_word [MAX_DEPTH];
    word_t            dn_word [MAX_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_eff;

    stat_t            status_reg;
    stat_t            status_next;
    word_t            rdval_reg;
    word_t            rdval_next;
    logic [CNT_W-1:0] cnt_out_reg;
    logic             full_reg;
    logic             empty_reg;

    logic [CNT_W-1:0] count_m1;
    logic [POS_W-1:0] ins_pos;
    logic [IDX_W-1:0] rd_idx;
    word_t            rd_word;

    // fixed neighbour taps for the shift network
    genvar g;
    generate
        for (g = 0; g < MAX_DEPTH; g++)
        begin : g_taps
            if (g == 0)
            begin : g_first
                assign up_word[g] = entries_reg[g];
            end
            else
            begin : g_up
                assign up_word[g] = entries_reg[g-1];
            end
            if (g == MAX_DEPTH - 1)
            begin : g_last
                assign dn_word[g] = entries_reg[g];
            end
            else
            begin : g_dn
                assign dn_word[g] = entries_reg[g+1];
            end
        end
    endgenerate

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(MAX_DEPTH))
        begin
            cap_eff = CNT_W'(MAX_DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign count_m1 = count_reg - CNT_W'(1);
    assign ins_pos  = (req_op_reg == OP_APPEND) ? count_reg : req_pos_reg;
    assign rd_idx   = (req_op_reg == OP_READ_LAST) ? count_m1[IDX_W-1:0]
                                                   : req_pos_reg[IDX_W-1:0];
    assign rd_word  = entries_reg[rd_idx];

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        status_next  = STAT_OK;
        rdval_next   = '0;
        unique case (req_op_reg) inside
            OP_INSERT_AT, OP_APPEND:
            begin
                if (ins_pos > count_reg)
                begin
                    status_next = STAT_BAD_IDX;
                end
                else if (count_reg >= cap_eff)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    for (int i = 0; i < MAX_DEPTH; i++)
                    begin
                        if (POS_W'(i) == ins_pos)
                        begin
                            entries_next[i] = req_elem_reg;
                        end
                        else if (POS_W'(i) > ins_pos && CNT_W'(i) <= count_reg)
                        begin
                            entries_next[i] = up_word[i];
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE_AT:
            begin
                if (req_pos_reg >= count_reg)
                begin
                    status_next = STAT_BAD_IDX;
                end
                else
                begin
                    for (int i = 0; i < MAX_DEPTH; i++)
                    begin
                        if (POS_W'(i) >= req_pos_reg && CNT_W'(i + 1) < count_reg)
                        begin
                            entries_next[i] = dn_word[i];
                        end
                    end
                    count_next = count_m1;
                end
            end
            OP_REMOVE_LAST:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    count_next = count_m1;
                end
            end
            OP_READ_AT:
            begin
                if (req_pos_reg >= count_reg)
                begin
                    status_next = STAT_BAD_IDX;
                end
                else
                begin
                    rdval_next = rd_word;
                end
            end
            OP_READ_LAST:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    rdval_next = rd_word;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = STAT_BAD_IDX;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CNT_W'(MAX_DEPTH);
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (cap_we)
            begin
                cap_reg <= cap_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg   <= opcode;
            req_pos_reg  <= position;
            req_elem_reg <= element;
        end
        if (cmd.exec)
        begin
            entries_reg <= entries_next;
            status_reg  <= status_next;
            rdval_reg   <= rdval_next;
            cnt_out_reg <= count_next;
            full_reg    <= (count_next >= cap_eff);
            empty_reg   <= (count_next == '0);
        end
    end

    assign status     = status_reg;
    assign read_value = rdval_reg;
    assign count      = cnt_out_reg;
    assign is_full    = full_reg;
    assign is_empty   = empty_reg;

endmodule

>>> hw/rtl/bounded_indexed_list.sv
// top level of the bounded indexed list: sequencer plus datapath
// depends on bil_pkg, bil_ctrl, bil_dpath and bounded_indexed_list_assert.svh
//
// an ordered list of up to 16 signed 32-bit entries held in flip-flops. each
// request word carries an opcode (insert at, append, remove at, remove last,
// read at, read last, clear), a position and an element, and gives exactly one
// result word: status, value read (zero unless a read succeeds), count after
// the request and the full and empty flags. a request runs as a latch step
// in which the word is latched, then an execute step in which the parallel
// shift network moves every entry at once and the result register is loaded;
// no new word is taken before the cycle after that. the result register sits
// between the two sides, so a new request is taken while a result still
// waits; only the execute cycle waits on a stalled output. the
// capacity register (reset 16) is clamped to 1..16 and may be written at any
// time the list is idle; cfg_ready is always high.
module bounded_indexed_list (
    input  logic                         clk,
    input  logic                         rst_n,

    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bil_pkg::OP_W-1:0]     opcode,
    input  logic [bil_pkg::POS_W-1:0]    position,
    input  bil_pkg::word_t               element,

    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bil_pkg::STAT_W-1:0]   status,
    output bil_pkg::word_t               read_value,
    output logic [bil_pkg::CNT_W-1:0]    count,
    output logic                         is_full,
    output logic                         is_empty,

    // capacity register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bil_pkg::CNT_W-1:0]    capacity
);
    import bil_pkg::*;

    `include "bounded_indexed_list_assert.svh"

    cmd_t cmd;

    // register writes never wait
    assign cfg_ready = 1'b1;

    bil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    bil_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (opcode),
        .position   (position),
        .element    (element),
        .cap_we     (cfg_valid && cfg_ready),
        .cap_data   (capacity),
        .status     (status),
        .read_value (read_value),
        .count      (count),
        .is_full    (is_full),
        .is_empty   (is_empty)
    );

    // execute only when the result register can take the word
    `BIL_ASSERT_NOW(a_exec_room, cmd.exec, (!out_valid || !out_stall), "result overwritten")
    // a taken request blocks the next one until it has run
    `BIL_ASSERT_NEXT(a_busy_after_take, (in_valid && !in_stall), in_stall, "request not held")
    // count never passes the array depth
    `BIL_ASSERT_NOW(a_count_bound, out_valid, (count <= CNT_W'(MAX_DEPTH)), "count overflow")
    // failed requests return zero data
    `BIL_ASSERT_NOW(a_zero_on_fail, (out_valid && status != STAT_OK), (read_value == '0),
                    "read value not zero on failure")
    // empty flag tracks the count
    `BIL_ASSERT_NOW(a_empty_flag, out_valid, (is_empty == (count == '0)), "empty flag wrong")

endmodule
